// File: rtl/sbt_pkg.sv
// Shared types and constants for the barrier synchronizer with timeout.
package sbt_pkg;

   typedef struct packed {
      logic        action;
      logic [3:0]  lane_index;
      logic [31:0] lane_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_lane;
      logic [31:0] out_value;
      logic        all_arrived;
      logic        last;
   } rsp_type;

   // Window close handed from the window tracker to the drain sequencer.
   typedef struct packed {
      logic start;
      logic complete;
   } flush_type;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARTIAL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LANES   = 2'd2;

   localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
   localparam logic        PARTIAL_RESET = 1'b0;
   localparam logic [4:0]  LANES_RESET   = 5'd16;

   localparam logic ACTION_UPDATE = 1'b0;

endpackage

// File: rtl/sync_barrier_with_timeout.sv
// Barrier synchronizer with timeout: collects one value per lane, emits the window.
//
// Input channel (req_*): each transfer is either a lane value update or one
// time tick. Updates store the lane's value and mark the lane; the first
// update of a window loads the timeout countdown, ticks count it down.
// Output channel (rsp_*): when all active lanes have arrived, or on timeout
// with emit_partial set, the marked lanes leave in ascending lane order, one
// per cycle unless the output stalls, the final one with last set. On timeout
// without emit_partial the window is dropped.
// Throughput: one input transfer per cycle while no window is draining.
// A closing transfer that starts a drain stalls the input from the next cycle
// until the window's final lane is in the output register; the lanes are read
// one by one through the single read port of the lane value store. The first
// result passes the pending mask, the store's read register and the output register.
// A stalled result holds in the output register; draining pauses behind it.
// Reset (synchronous) clears the window, empties the output and loads the
// register defaults: timeout 1000 ticks, emit_partial 0, lanes_in_use 16.
// The value store is not cleared; only marked lanes are ever read.
module sync_barrier_with_timeout #(
   parameter int unsigned NUM_LANES  = 16,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sbt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sbt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [sbt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sbt_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import sbt_pkg::*;

   // lane index is 4 bits wide, so at most 16 lanes can ever be marked
   localparam int unsigned MASK_LANES = (NUM_LANES < 16) ? NUM_LANES : 16;
   localparam int unsigned IDX_BITS   = (MASK_LANES > 1) ? $clog2(MASK_LANES) : 1;

   logic [31:0] timeout_ff, timeout_in;
   logic        partial_ff, partial_in;
   logic [4:0]  lanes_ff, lanes_in;

   logic                  req_take;
   logic                  busy;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   flush_type             flush;
   logic [MASK_LANES-1:0] flush_mask;

   always_comb begin
      timeout_in = timeout_ff;
      partial_in = partial_ff;
      lanes_in   = lanes_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_data;
            CSR_PARTIAL: partial_in = csr_data[0];
            CSR_LANES:   lanes_in   = csr_data[4:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         partial_ff <= PARTIAL_RESET;
         lanes_ff   <= LANES_RESET;
      end else begin
         timeout_ff <= timeout_in;
         partial_ff <= partial_in;
         lanes_ff   <= lanes_in;
      end
   end

   assign req_stall = busy;
   assign req_take  = req_valid && !busy;

   sbt_window #(
      .NUM_LANES  (NUM_LANES),
      .MASK_LANES (MASK_LANES),
      .IDX_BITS   (IDX_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .req_take      (req_take),
      .req_data      (req_data),
      .timeout_ticks (timeout_ff),
      .emit_partial  (partial_ff),
      .lanes_in_use  (lanes_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .flush         (flush),
      .flush_mask    (flush_mask)
   );

   sbt_value_mem #(
      .DEPTH     (MASK_LANES),
      .WIDTH     (VALUE_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbt_drain #(
      .MASK_LANES (MASK_LANES),
      .IDX_BITS   (IDX_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .flush      (flush),
      .flush_mask (flush_mask),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/sbt_value_mem.sv
// Lane value store: one write port, one registered read port.
module sbt_value_mem #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned WIDTH     = 32,
   parameter int unsigned ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sbt_window.sv
// Window tracker: arrival mask, arrival count and timeout countdown.
module sbt_window #(
   parameter int unsigned NUM_LANES  = 16,
   parameter int unsigned MASK_LANES = 16,
   parameter int unsigned IDX_BITS   = 4,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_take,
   input  sbt_pkg::req_type        req_data,
   input  logic [31:0]             timeout_ticks,
   input  logic                    emit_partial,
   input  logic [4:0]              lanes_in_use,
   output logic                    wr_en,
   output logic [IDX_BITS-1:0]     wr_addr,
   output logic [VALUE_BITS-1:0]   wr_data,
   output sbt_pkg::flush_type      flush,
   output logic [MASK_LANES-1:0]   flush_mask
);

   import sbt_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(MASK_LANES + 1);
   localparam int unsigned EFF_BITS = $clog2(NUM_LANES + 1);

   logic [MASK_LANES-1:0] mask_ff, mask_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [31:0]           cd_ff, cd_in;
   logic                  run_ff, run_in;

   logic [EFF_BITS-1:0]   eff;
   logic [IDX_BITS-1:0]   idx;
   logic                  in_range;
   logic                  expired;
   logic                  complete;

   // effective lane count, clamped to 1..NUM_LANES
   always_comb begin
      if (lanes_in_use == 5'd0) begin
         eff = EFF_BITS'(1);
      end else if (32'(lanes_in_use) > 32'(NUM_LANES)) begin
         eff = EFF_BITS'(NUM_LANES);
      end else begin
         eff = EFF_BITS'(lanes_in_use);
      end
   end

   assign idx      = req_data.lane_index[IDX_BITS-1:0];
   assign in_range = 32'(req_data.lane_index) < 32'(eff);
   assign wr_addr  = idx;
   assign wr_data  = VALUE_BITS'(req_data.lane_value);

   always_comb begin
      mask_in    = mask_ff;
      count_in   = count_ff;
      cd_in      = cd_ff;
      run_in     = run_ff;
      wr_en      = 1'b0;
      expired    = 1'b0;
      complete   = 1'b0;
      flush      = '0;
      flush_mask = '0;
      if (req_take) begin
         if (req_data.action == ACTION_UPDATE) begin
            if (in_range) begin
               if (!run_ff) begin
                  cd_in  = (timeout_ticks == 32'd0) ? 32'd1 : timeout_ticks;
                  run_in = 1'b1;
               end
               if (!mask_ff[idx]) begin
                  mask_in[idx] = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
               wr_en = 1'b1;
            end
         end else if (run_ff) begin
            if (cd_ff != 32'd0) begin
               cd_in = cd_ff - 32'd1;
            end
            expired = (cd_in == 32'd0);
         end
         complete = (count_in != '0) && (32'(count_in) >= 32'(eff));
         if (complete || expired) begin
            flush.start    = complete || emit_partial;
            flush.complete = complete;
            flush_mask     = mask_in;
            mask_in        = '0;
            count_in       = '0;
            cd_in          = 32'd0;
            run_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         count_ff <= '0;
         cd_ff    <= 32'd0;
         run_ff   <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         count_ff <= count_in;
         cd_ff    <= cd_in;
         run_ff   <= run_in;
      end
   end

endmodule

// File: rtl/sbt_drain.sv
// Drain sequencer: walks the closed window's lanes through the value store.
module sbt_drain #(
   parameter int unsigned MASK_LANES = 16,
   parameter int unsigned IDX_BITS   = 4,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbt_pkg::flush_type    flush,
   input  logic [MASK_LANES-1:0] flush_mask,
   output logic                  rd_en,
   output logic [IDX_BITS-1:0]   rd_addr,
   input  logic [VALUE_BITS-1:0] rd_data,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sbt_pkg::rsp_type      rsp_data
);

   import sbt_pkg::*;

   logic [MASK_LANES-1:0] pend_ff, pend_in;
   logic                  cmp_ff, cmp_in;
   logic                  p_valid_ff, p_valid_in;
   logic [IDX_BITS-1:0]   p_lane_ff, p_lane_in;
   logic                  p_last_ff, p_last_in;
   logic                  p_cmp_ff, p_cmp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [MASK_LANES-1:0] low;
   logic [MASK_LANES-1:0] rest;
   logic [IDX_BITS-1:0]   low_idx;
   logic                  o_free;
   logic                  move;
   logic                  issue;

   assign low  = pend_ff & (~pend_ff + 1'b1);
   assign rest = pend_ff & ~low;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MASK_LANES; i++) begin
         if (low[i]) begin
            low_idx = low_idx | IDX_BITS'(i);
         end
      end
   end

   assign o_free  = !rsp_valid_ff || !rsp_stall;
   assign move    = p_valid_ff && o_free;
   // read data sits in the store's output register until it moves on
   assign issue   = (pend_ff != '0) && (!p_valid_ff || move);
   assign rd_en   = issue;
   assign rd_addr = low_idx;
   assign busy    = (pend_ff != '0) || p_valid_ff;

   always_comb begin
      pend_in    = pend_ff;
      cmp_in     = cmp_ff;
      p_valid_in = p_valid_ff;
      p_lane_in  = p_lane_ff;
      p_last_in  = p_last_ff;
      p_cmp_in   = p_cmp_ff;
      if (flush.start) begin
         pend_in = flush_mask;
         cmp_in  = flush.complete;
      end else if (issue) begin
         pend_in = rest;
      end
      if (issue) begin
         p_valid_in = 1'b1;
         p_lane_in  = low_idx;
         p_last_in  = (rest == '0);
         p_cmp_in   = cmp_ff;
      end else if (move) begin
         p_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (o_free) begin
         rsp_valid_in = move;
      end
      if (move) begin
         rsp_data_in.out_lane    = 4'(p_lane_ff);
         rsp_data_in.out_value   = 32'(rd_data);
         rsp_data_in.all_arrived = p_cmp_ff;
         rsp_data_in.last        = p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff      <= cmp_in;
      p_lane_ff   <= p_lane_in;
      p_last_ff   <= p_last_in;
      p_cmp_ff    <= p_cmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/sbt_checker.sv
// Port-level checks for the barrier synchronizer, bound to the top level.
module sbt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sbt_pkg::rsp_type rsp_data
);

   import sbt_pkg::*;

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // input stays closed while a window is still draining
   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input open during window drain");

   // a window drains without gaps and keeps its completion flag
   a_drain_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && rsp_data.all_arrived == $past(rsp_data.all_arrived))
      else $error("gap or flag change inside a window");

   a_lane_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_data.out_lane > $past(rsp_data.out_lane))
      else $error("lanes out of order");

endmodule

bind sync_barrier_with_timeout sbt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: sim/barrier_check_pkg.sv
`timescale 1ns / 1ps
// Lane window predictor and result scoreboard for the barrier synchronizer testbench.
package barrier_check_pkg;
   import sbt_pkg::*;

   localparam int unsigned LANES = 16;

   class barrier_scoreboard;
      logic [31:0] timeout_ticks;
      logic        emit_partial;
      logic [4:0]  lanes_in_use;

      logic [LANES-1:0] window_mask;
      logic [31:0]      lane_store [LANES];
      int unsigned      window_count;
      logic [31:0]      ticks_left;
      bit               window_open;

      rsp_type     expected_emits [$];
      int unsigned failures;
      // accepted input transfers, ignored updates and idle ticks included
      int unsigned worked;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         emit_partial  = PARTIAL_RESET;
         lanes_in_use  = LANES_RESET;
         failures      = 0;
         worked        = 0;
         clear_window();
      endfunction

      function void clear_window();
         window_mask  = '0;
         window_count = 0;
         ticks_left   = '0;
         window_open  = 1'b0;
      endfunction

      function int unsigned effective_lanes();
         if (lanes_in_use == 0) return 1;
         if (lanes_in_use > LANES) return LANES;
         return 32'(lanes_in_use);
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index, logic [31:0] value);
         case (index)
            CSR_TIMEOUT: timeout_ticks = value;
            CSR_PARTIAL: emit_partial = value[0];
            CSR_LANES:   lanes_in_use = value[4:0];
            default:     ;
         endcase
      endfunction

      // marked lanes leave in ascending order, last flag on the final one
      function void emit_window(bit complete);
         rsp_type     entry;
         int unsigned remaining;
         remaining = $countones(window_mask);
         for (int i = 0; i < LANES; i++) begin
            if (window_mask[i]) begin
               remaining--;
               entry.out_lane    = 4'(i);
               entry.out_value   = lane_store[i];
               entry.all_arrived = complete;
               entry.last        = (remaining == 0);
               expected_emits.push_back(entry);
            end
         end
      endfunction

      function void take_request(req_type item);
         int unsigned span;
         bit          expired;
         span    = effective_lanes();
         expired = 1'b0;
         worked++;
         if (item.action == ACTION_UPDATE) begin
            if (item.lane_index < span) begin
               if (!window_open) begin
                  ticks_left  = (timeout_ticks == 0) ? 32'd1 : timeout_ticks;
                  window_open = 1'b1;
               end
               if (!window_mask[item.lane_index]) begin
                  window_mask[item.lane_index] = 1'b1;
                  window_count++;
               end
               lane_store[item.lane_index] = item.lane_value;
            end
         end else if (window_open) begin
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) expired = 1'b1;
         end
         // completion takes priority over a simultaneous expiry
         if (window_count != 0 && window_count >= span) begin
            emit_window(1'b1);
            clear_window();
         end else if (expired) begin
            if (emit_partial) emit_window(1'b0);
            clear_window();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_emission(rsp_type got);
         rsp_type want;
         if (expected_emits.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual lane %0d value %h",
                     $time, got.out_lane, got.out_value);
            failures++;
            return;
         end
         want = expected_emits.pop_front();
         compare_field("out_lane", 32'(want.out_lane), 32'(got.out_lane));
         compare_field("out_value", want.out_value, got.out_value);
         compare_field("all_arrived", 32'(want.all_arrived), 32'(got.all_arrived));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench: drives lane updates and ticks, checks emitted windows.
module tb_top;
   import sbt_pkg::*;
   import barrier_check_pkg::*;

   localparam logic        ACTION_TICK   = 1'b1;
   localparam int unsigned ITEM_TARGET   = 280;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned QUIET_LIMIT   = 5000;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   bit sender_bursts = 1'b0;

   barrier_scoreboard sb = new();

   sync_barrier_with_timeout dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // results are checked before the same edge's input is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_emission(rsp_data);
         if (req_valid && !req_stall) sb.take_request(req_data);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 32'd0;
      if (pick == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic req_type update_item(logic [3:0] lane, logic [31:0] value);
      req_type item;
      item.action     = ACTION_UPDATE;
      item.lane_index = lane;
      item.lane_value = value;
      return item;
   endfunction

   // lane and value are don't-care on a tick, so they carry noise
   function automatic req_type tick_item();
      req_type item;
      item.action     = ACTION_TICK;
      item.lane_index = 4'($urandom);
      item.lane_value = random_value();
      return item;
   endfunction

   function automatic req_type random_request(int unsigned span);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 68) return update_item(4'($urandom_range(0, span - 1)), random_value());
      if (pick < 93) return tick_item();
      return update_item(4'($urandom_range(0, LANES - 1)), random_value());
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      gap = sender_bursts ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold input until every predicted lane is out, then let the design settle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_emits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   task automatic apply_settings(input logic [31:0] ticks, input logic partial,
                                 input logic [4:0] lanes);
      write_reg(CSR_TIMEOUT, ticks);
      write_reg(CSR_PARTIAL, {31'd0, partial});
      write_reg(CSR_LANES, {27'd0, lanes});
      csr_write <= 1'b0;
   endtask

   initial begin : receiver
      int unsigned hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         hold = gap_length();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
            @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [31:0] ticks;
      logic [4:0]  lanes;
      int unsigned pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: tick with no window open does nothing
      send_item(tick_item());

      // lane count 0 acts as one lane; lane 5 is then inactive
      settle();
      apply_settings(32'd0, 1'b1, 5'd0);
      send_item(update_item(4'd5, 32'h1234_5678));
      send_item(update_item(4'd0, 32'hFFFF_FFFF));

      // timeout with partial output
      settle();
      apply_settings(32'd1, 1'b1, 5'd2);
      send_item(update_item(4'd1, 32'd0));
      send_item(tick_item());

      // timeout with window dropped
      settle();
      apply_settings(32'd1, 1'b0, 5'd2);
      send_item(update_item(4'd0, 32'hA5A5_5A5A));
      send_item(tick_item());

      // lane count lowered mid-window; next tick both expires and completes
      settle();
      apply_settings(32'd2, 1'b1, 5'd3);
      send_item(update_item(4'd0, 32'h8000_0001));
      send_item(update_item(4'd2, 32'h7FFF_FFFE));
      send_item(tick_item());
      settle();
      apply_settings(32'd2, 1'b1, 5'd2);
      send_item(tick_item());

      // oversized lane count, zero timeout, repeated arrivals on the top lane
      settle();
      apply_settings(32'd0, 1'b1, 5'd31);
      send_item(update_item(4'd15, 32'h0F0F_0F0F));
      send_item(update_item(4'd15, 32'hF0F0_F0F0));
      send_item(tick_item());

      while (sb.worked < ITEM_TARGET) begin
         pick  = $urandom_range(0, 19);
         ticks = (pick < 2) ? 32'd0 :
                 (pick < 4) ? 32'hFFFF_FFFF :
                 (pick == 4) ? $urandom : 32'($urandom_range(1, 24));
         pick  = $urandom_range(0, 19);
         lanes = (pick < 2) ? 5'd0 :
                 (pick < 4) ? 5'($urandom_range(17, 31)) :
                 (pick < 8) ? 5'd16 : 5'($urandom_range(1, 8));
         settle();
         apply_settings(ticks, 1'($urandom_range(0, 1)), lanes);
         sender_bursts = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(10, 40)) send_item(random_request(sb.effective_lanes()));
      end

      settle();
      if (sb.failures == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: sync_barrier_with_timeout.f
rtl/sbt_pkg.sv
rtl/sbt_value_mem.sv
rtl/sbt_window.sv
rtl/sbt_drain.sv
rtl/sync_barrier_with_timeout.sv
rtl/sbt_checker.sv
sim/barrier_check_pkg.sv
sim/tb_top.sv
